// File: src/gc2d_pkg.sv
package gc2d_pkg;

  localparam int unsigned MaxChannels = 16;
  localparam int unsigned MaxKernel   = 7;
  localparam int unsigned MaxHeight   = 32;
  localparam int unsigned MaxWidth    = 32;
  localparam int unsigned DataWidth   = 16;
  localparam int unsigned AccWidth    = 48;

  // Stores are laid out on power-of-two strides: oc, ic, kernel row, kernel col
  // for weights and ic, row, col for pixels.
  localparam int unsigned WAddrWidth = 14;
  localparam int unsigned XAddrWidth = 14;
  localparam int unsigned StoreDepth = 16384;

  typedef enum logic [1:0] {
    CMD_LOAD_W  = 2'd0,
    CMD_LOAD_X  = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_IN_CH   = 3'd0,
    REG_OUT_CH  = 3'd1,
    REG_GROUPS  = 3'd2,
    REG_KERNEL  = 3'd3,
    REG_STRIDE  = 3'd4,
    REG_PAD     = 3'd5,
    REG_HEIGHT  = 3'd6,
    REG_WIDTH   = 3'd7
  } reg_e;

  typedef struct packed {
    logic clear;
    logic valid;
    logic keep;
  } mac_ctl_t;

endpackage

// File: src/gc2d_if.sv
interface gc2d_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  dst_ch;
  logic [3:0]  src_ch;
  logic [4:0]  row;
  logic [4:0]  col;
  logic signed [15:0] value;

  modport source (output valid, command, dst_ch, src_ch, row, col, value,
                  input ready);
  modport sink (input valid, command, dst_ch, src_ch, row, col, value,
                output ready);
endinterface

interface gc2d_res_if;
  logic        valid;
  logic        ready;
  logic signed [47:0] out_value;
  logic        status;
  logic [3:0]  res_channel;
  logic [4:0]  res_row;
  logic [4:0]  res_col;

  modport source (output valid, out_value, status, res_channel, res_row, res_col,
                  input ready);
  modport sink (input valid, out_value, status, res_channel, res_row, res_col,
                output ready);
endinterface

// File: src/gc2d_ram.sv
module gc2d_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: src/gc2d_mac.sv
module gc2d_mac (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gc2d_pkg::mac_ctl_t   ctl_i,
  input  logic signed [15:0]   w_i,
  input  logic signed [15:0]   x_i,
  output logic signed [47:0]   acc_o,
  output logic                 busy_o
);
  import gc2d_pkg::*;

  logic signed [31:0] prod_q;
  logic               prod_v_q;
  logic               keep_q;
  logic signed [47:0] acc_q;

  // Padded taps are dropped at the product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      keep_q   <= 1'b0;
    end else begin
      prod_v_q <= ctl_i.valid;
      keep_q   <= ctl_i.keep;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= w_i * x_i;
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (prod_v_q && keep_q) begin
      acc_q <= acc_q + 48'(prod_q);
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_v_q;

endmodule

// File: src/grouped_conv2d_engine.sv
// Grouped 2D convolution engine over a weight store and a feature-map store.
// Load beats are taken one per cycle while no compute is in progress. A compute result waits on
// the divide steps (larger per-group channel count), the group search steps and then the
// (in_ch/groups)*K*K taps, which go through the single multiply-accumulate fed by one read
// port per store. A bad setting or position is answered with an error status and no taps.
// One compute at a time. Reset sets control state and register defaults; stores stay undefined.
module grouped_conv2d_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  gc2d_cmd_if.sink    cmd,
  gc2d_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gc2d_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DIV, S_FIND, S_RUN, S_DRAIN, S_DONE
  } state_e;

  // Configuration registers over APB; the user must write them only while idle (not enforced).
  logic [4:0] in_ch_q, out_ch_q, grp_q;
  logic [2:0] ksz_q, stride_q;
  logic [1:0] pad_q;
  logic [5:0] in_h_q, in_w_q;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= 5'd1;
      out_ch_q <= 5'd1;
      grp_q    <= 5'd1;
      ksz_q    <= 3'd3;
      stride_q <= 3'd1;
      pad_q    <= 2'd0;
      in_h_q   <= 6'd32;
      in_w_q   <= 6'd32;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[4:2]))
        REG_IN_CH:  in_ch_q  <= pwdata[4:0];
        REG_OUT_CH: out_ch_q <= pwdata[4:0];
        REG_GROUPS: grp_q    <= pwdata[4:0];
        REG_KERNEL: ksz_q    <= pwdata[2:0];
        REG_STRIDE: stride_q <= pwdata[2:0];
        REG_PAD:    pad_q    <= pwdata[1:0];
        REG_HEIGHT: in_h_q   <= pwdata[5:0];
        REG_WIDTH:  in_w_q   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[4:2]))
      REG_IN_CH:  prdata = 32'(in_ch_q);
      REG_OUT_CH: prdata = 32'(out_ch_q);
      REG_GROUPS: prdata = 32'(grp_q);
      REG_KERNEL: prdata = 32'(ksz_q);
      REG_STRIDE: prdata = 32'(stride_q);
      REG_PAD:    prdata = 32'(pad_q);
      REG_HEIGHT: prdata = 32'(in_h_q);
      REG_WIDTH:  prdata = 32'(in_w_q);
      default:    prdata = '0;
    endcase
  end

  state_e state_q;

  // Latched compute beat.
  logic [3:0] oc_q;
  logic [4:0] row_q, col_q;
  logic       err_q;

  // Group setup: per-group channel counts by repeated addition, then the
  // first input channel of the group holding oc_q.
  logic [5:0] acc_i_q, acc_o_q;
  logic [4:0] ipr_q, opr_q;
  logic [5:0] ob_q, ib_q;

  // Window position and tap counters.
  logic signed [9:0] base_r_q, base_c_q;
  logic [4:0] cn_q;
  logic [2:0] ki_q, kj_q;
  logic       iss_v_q, iss_keep_q;

  logic        in_acc;
  cmd_e        cmd_code;
  logic        wload_ok, xload_ok;
  assign cmd.ready = (state_q == S_IDLE);
  assign in_acc    = cmd.valid && cmd.ready;
  assign cmd_code  = cmd_e'(cmd.command);

  assign wload_ok = (5'(cmd.dst_ch) < out_ch_q) && (5'(cmd.src_ch) < in_ch_q) &&
                    (cmd.row < 5'(ksz_q)) && (cmd.col < 5'(ksz_q));
  assign xload_ok = (5'(cmd.src_ch) < in_ch_q) &&
                    (6'(cmd.row) < in_h_q) && (6'(cmd.col) < in_w_q);

  // Output position checks: a position is inside when pos*stride + K <= n + 2*pad.
  logic [7:0] rs, cs;
  logic       cfg_ok, pos_ok;
  assign rs = 8'(row_q) * 8'(stride_q);
  assign cs = 8'(col_q) * 8'(stride_q);
  assign cfg_ok = (in_ch_q != 5'd0) && (in_ch_q <= 5'(MaxChannels)) &&
                  (out_ch_q != 5'd0) && (out_ch_q <= 5'(MaxChannels)) &&
                  (grp_q != 5'd0) && (ksz_q != 3'd0) && (stride_q != 3'd0) &&
                  (in_h_q != 6'd0) && (in_h_q <= 6'(MaxHeight)) &&
                  (in_w_q != 6'd0) && (in_w_q <= 6'(MaxWidth));
  assign pos_ok = (5'(oc_q) < out_ch_q) &&
                  (9'(rs) + 9'(ksz_q) <= 9'(in_h_q) + 9'({pad_q, 1'b0})) &&
                  (9'(cs) + 9'(ksz_q) <= 9'(in_w_q) + 9'({pad_q, 1'b0}));

  // Tap address generation during the run.
  logic signed [9:0] ih, iw;
  logic [3:0] ch;
  logic       tap_in, last_tap;
  assign ih = base_r_q + 10'(ki_q);
  assign iw = base_c_q + 10'(kj_q);
  assign ch = 4'(ib_q + 6'(cn_q));
  assign tap_in = (ih >= 0) && (ih < $signed(10'(in_h_q))) &&
                  (iw >= 0) && (iw < $signed(10'(in_w_q)));
  assign last_tap = (cn_q == ipr_q - 5'd1) && (ki_q == ksz_q - 3'd1) &&
                    (kj_q == ksz_q - 3'd1);

  logic                  w_we, x_we;
  logic [WAddrWidth-1:0] w_addr;
  logic [XAddrWidth-1:0] x_addr;
  logic [15:0]           w_rd, x_rd;

  assign w_we = in_acc && (cmd_code == CMD_LOAD_W) && wload_ok;
  assign x_we = in_acc && (cmd_code == CMD_LOAD_X) && xload_ok;

  always_comb begin
    if (state_q == S_RUN) begin
      w_addr = {oc_q, ch, ki_q, kj_q};
      x_addr = {ch, ih[4:0], iw[4:0]};
    end else begin
      w_addr = {cmd.dst_ch, cmd.src_ch, cmd.row[2:0], cmd.col[2:0]};
      x_addr = {cmd.src_ch, cmd.row, cmd.col};
    end
  end

  gc2d_ram #(.Width(DataWidth), .Depth(StoreDepth)) u_wram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .addr_i  (w_addr),
    .wdata_i (cmd.value),
    .rdata_o (w_rd)
  );

  gc2d_ram #(.Width(DataWidth), .Depth(StoreDepth)) u_xram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .addr_i  (x_addr),
    .wdata_i (cmd.value),
    .rdata_o (x_rd)
  );

  // The accumulator is cleared while the group search runs, before any tap.
  mac_ctl_t           mac_ctl;
  logic signed [47:0] mac_acc;
  logic               mac_busy;
  assign mac_ctl.clear = (state_q == S_FIND);
  assign mac_ctl.valid = iss_v_q;
  assign mac_ctl.keep  = iss_keep_q;

  gc2d_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .w_i    ($signed(w_rd)),
    .x_i    ($signed(x_rd)),
    .acc_o  (mac_acc),
    .busy_o (mac_busy)
  );

  logic res_valid_q;
  assign res.valid = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      iss_v_q     <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      // A tap is issued in every run cycle; its store data arrive in the next cycle, with the issue flag.
      iss_v_q <= (state_q == S_RUN);
      if (res_valid_q && res.ready && (state_q != S_DONE)) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && cmd_code == CMD_COMPUTE) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (cfg_ok && pos_ok) begin
            state_q <= S_DIV;
          end else begin
            err_q   <= 1'b1;
            state_q <= S_DONE;
          end
        end
        S_DIV: begin
          if (acc_i_q >= 6'(in_ch_q) && acc_o_q >= 6'(out_ch_q)) begin
            if (acc_i_q == 6'(in_ch_q) && acc_o_q == 6'(out_ch_q)) begin
              state_q <= S_FIND;
            end else begin
              err_q   <= 1'b1;
              state_q <= S_DONE;
            end
          end
        end
        S_FIND: begin
          if (6'(oc_q) < ob_q + 6'(opr_q)) begin
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (last_tap) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!iss_v_q && !mac_busy) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid_q || res.ready) begin
            res_valid_q <= 1'b1;
            err_q       <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk_i) begin
    iss_keep_q <= tap_in;
    unique case (state_q)
      S_IDLE: begin
        oc_q  <= cmd.dst_ch;
        row_q <= cmd.row;
        col_q <= cmd.col;
      end
      S_CHECK: begin
        acc_i_q  <= '0;
        acc_o_q  <= '0;
        ipr_q    <= '0;
        opr_q    <= '0;
        ob_q     <= '0;
        ib_q     <= '0;
        base_r_q <= $signed(10'(rs)) - $signed(10'(pad_q));
        base_c_q <= $signed(10'(cs)) - $signed(10'(pad_q));
      end
      S_DIV: begin
        if (acc_i_q < 6'(in_ch_q)) begin
          acc_i_q <= acc_i_q + 6'(grp_q);
          ipr_q   <= ipr_q + 5'd1;
        end
        if (acc_o_q < 6'(out_ch_q)) begin
          acc_o_q <= acc_o_q + 6'(grp_q);
          opr_q   <= opr_q + 5'd1;
        end
      end
      S_FIND: begin
        cn_q <= '0;
        ki_q <= '0;
        kj_q <= '0;
        if (6'(oc_q) >= ob_q + 6'(opr_q)) begin
          ob_q <= ob_q + 6'(opr_q);
          ib_q <= ib_q + 6'(ipr_q);
        end
      end
      S_RUN: begin
        if (kj_q == ksz_q - 3'd1) begin
          kj_q <= '0;
          if (ki_q == ksz_q - 3'd1) begin
            ki_q <= '0;
            cn_q <= cn_q + 5'd1;
          end else begin
            ki_q <= ki_q + 3'd1;
          end
        end else begin
          kj_q <= kj_q + 3'd1;
        end
      end
      S_DONE: begin
        if (!res_valid_q || res.ready) begin
          res.out_value   <= err_q ? '0 : mac_acc;
          res.status      <= err_q;
          res.res_channel <= oc_q;
          res.res_row     <= row_q;
          res.res_col     <= col_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sim/gc2d_checker.sv
// Watches the command and result channels of the convolution engine, keeps
// its own copy of the registers and both stores, predicts every result and
// compares it with what the engine returns.
module gc2d_checker
  import gc2d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  gc2d_cmd_if         cmd,
  gc2d_res_if         res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic signed [47:0] sum;
    logic               status;
    logic [3:0]         channel;
    logic [4:0]         row;
    logic [4:0]         col;
  } conv_result_t;

  conv_result_t conv_q[$];

  logic signed [15:0] weight_mem[MaxChannels][MaxChannels][MaxKernel][MaxKernel];
  logic signed [15:0] pixel_mem[MaxChannels][MaxHeight][MaxWidth];

  logic [4:0] n_in, n_out, n_groups;
  logic [2:0] ksize, step;
  logic [1:0] padding;
  logic [5:0] height, width;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int span_out(input int n);
    int span;
    span = n + 2 * padding;
    if (span < ksize) return 0;
    return (span - ksize) / step + 1;
  endfunction

  function automatic bit config_sane();
    if (n_in < 1 || n_in > MaxChannels || n_out < 1 || n_out > MaxChannels) return 0;
    if (n_groups < 1 || n_in % n_groups != 0 || n_out % n_groups != 0) return 0;
    if (ksize < 1 || ksize > MaxKernel || step < 1) return 0;
    if (height < 1 || height > MaxHeight || width < 1 || width > MaxWidth) return 0;
    return 1;
  endfunction

  function automatic conv_result_t predict_output(input int oc, input int r, input int c);
    conv_result_t e;
    logic signed [63:0] acc;
    int ic_per, oc_per, first, ih, iw;
    acc = 0;
    e.status = 0;
    if (!config_sane() || oc >= n_out || r >= span_out(height) || c >= span_out(width)) begin
      e.status = 1;
    end else begin
      ic_per = n_in / n_groups;
      oc_per = n_out / n_groups;
      first = (oc / oc_per) * ic_per;
      for (int ch = first; ch < first + ic_per; ch++) begin
        for (int i = 0; i < ksize; i++) begin
          ih = r * step + i - padding;
          if (ih < 0 || ih >= height) continue;
          for (int j = 0; j < ksize; j++) begin
            iw = c * step + j - padding;
            if (iw < 0 || iw >= width) continue;
            acc += 64'(weight_mem[oc][ch][i][j]) * 64'(pixel_mem[ch][ih][iw]);
          end
        end
      end
    end
    e.sum = acc[47:0];
    e.channel = oc[3:0];
    e.row = r[4:0];
    e.col = c[4:0];
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    conv_result_t e;
    if (!rst_ni) begin
      n_in <= 1; n_out <= 1; n_groups <= 1; ksize <= 3;
      step <= 1; padding <= 0; height <= 32; width <= 32;
      conv_q.delete();
      pending = 0;
    end else begin
      // Register writes land on the access phase of the bus transfer.
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[4:2]))
          REG_IN_CH:  n_in <= pwdata[4:0];
          REG_OUT_CH: n_out <= pwdata[4:0];
          REG_GROUPS: n_groups <= pwdata[4:0];
          REG_KERNEL: ksize <= pwdata[2:0];
          REG_STRIDE: step <= pwdata[2:0];
          REG_PAD:    padding <= pwdata[1:0];
          REG_HEIGHT: height <= pwdata[5:0];
          REG_WIDTH:  width <= pwdata[5:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        case (cmd_e'(cmd.command))
          CMD_LOAD_W:
            if (cmd.dst_ch < n_out && cmd.src_ch < n_in && cmd.row < ksize &&
                cmd.row < MaxKernel && cmd.col < ksize && cmd.col < MaxKernel)
              weight_mem[cmd.dst_ch][cmd.src_ch][cmd.row][cmd.col] = cmd.value;
          CMD_LOAD_X:
            if (cmd.src_ch < n_in && cmd.row < height && cmd.col < width)
              pixel_mem[cmd.src_ch][cmd.row][cmd.col] = cmd.value;
          CMD_COMPUTE:
            conv_q.push_back(predict_output(cmd.dst_ch, cmd.row, cmd.col));
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (conv_q.size() == 0) begin
          report("result beat arrived with no compute outstanding");
        end else begin
          e = conv_q.pop_front();
          if (res.out_value !== e.sum)
            report($sformatf("out_value %0d, expected %0d", res.out_value, e.sum));
          if (res.status !== e.status)
            report($sformatf("status %0b, expected %0b", res.status, e.status));
          if (res.res_channel !== e.channel)
            report($sformatf("res_channel %0d, expected %0d", res.res_channel, e.channel));
          if (res.res_row !== e.row)
            report($sformatf("res_row %0d, expected %0d", res.res_row, e.row));
          if (res.res_col !== e.col)
            report($sformatf("res_col %0d, expected %0d", res.res_col, e.col));
        end
      end
      pending = conv_q.size();
    end
  end

endmodule

// File: sim/grouped_conv2d_engine_tb.sv
// Top of the convolution engine testbench. It makes the clock and the single
// reset, writes the registers over the APB port, sends command beats and
// drives the result-side ready. All prediction and comparison happens in the
// checker instance; this module only reads its failure and pending counts.
module grouped_conv2d_engine_tb;
  import gc2d_pkg::*;

  // A compute beat never takes as long as this, so it is a safe drain
  // time before touching the registers and at the end of the run.
  localparam int DrainCycles = 1000;
  localparam longint CycleLimit = 4_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  longint      cycle_count = 0;
  int          beats_sent;

  // Register values as last written, indexed by register code.
  int cfg[8];

  // Which store entries hold a written value, so that a compute never reads
  // an entry whose content is still undefined.
  bit w_written[MaxChannels][MaxChannels][MaxKernel][MaxKernel];
  bit x_written[MaxChannels][MaxHeight][MaxWidth];

  gc2d_cmd_if cmd_bus();
  gc2d_res_if res_bus();

  grouped_conv2d_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd     (cmd_bus),
    .res     (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gc2d_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd        (cmd_bus),
    .res        (res_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // The run is bounded by a plain cycle count, well above the slowest
  // correct run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** grouped_conv2d_engine: FAILED **");
      $finish;
    end
  end

  // Idle lengths: mostly none, often short, rarely long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 99) return $urandom_range(4, 12);
    return $urandom_range(30, 100);
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Output extent along one axis under the registers as last written.
  function automatic int axis_len(input int n);
    int span;
    span = n + 2 * cfg[REG_PAD];
    if (span < cfg[REG_KERNEL]) return 0;
    return (span - cfg[REG_KERNEL]) / cfg[REG_STRIDE] + 1;
  endfunction

  // Result side: random stalls, plus one long hold-off once 300 beats have
  // gone in, so that the engine fills up and stops taking commands.
  initial begin
    int n;
    bit held;
    held = 0;
    res_bus.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && beats_sent >= 300) begin
        held = 1;
        res_bus.ready <= 0;
        repeat (3000) @(posedge clk_i);
      end else begin
        n = pick_gap();
        if (n == 0) begin
          res_bus.ready <= 1;
        end else begin
          res_bus.ready <= 0;
          repeat (n - 1) @(posedge clk_i);
        end
      end
    end
  end

  // One command beat, with a random gap before it. Valid stays high between
  // back-to-back beats. Written flags follow the engine's load bounds.
  task automatic send(input cmd_e c, input int oc, input int ic, input int r, input int cl,
                      input logic signed [15:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_bus.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid <= 1;
    cmd_bus.command <= c;
    cmd_bus.dst_ch <= oc[3:0];
    cmd_bus.src_ch <= ic[3:0];
    cmd_bus.row <= r[4:0];
    cmd_bus.col <= cl[4:0];
    cmd_bus.value <= v;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    if (c == CMD_LOAD_W && oc < cfg[REG_OUT_CH] && ic < cfg[REG_IN_CH] &&
        r < cfg[REG_KERNEL] && r < MaxKernel && cl < cfg[REG_KERNEL] && cl < MaxKernel)
      w_written[oc][ic][r][cl] = 1;
    if (c == CMD_LOAD_X && ic < cfg[REG_IN_CH] && r < cfg[REG_HEIGHT] &&
        cl < cfg[REG_WIDTH])
      x_written[ic][r][cl] = 1;
    beats_sent++;
  endtask

  // A compute at a legal position, preceded by loads of every weight and
  // pixel that it reads and that has not been written yet.
  task automatic send_compute(input int oc, input int r, input int cl);
    int ic_per, oc_per, first, ih, iw;
    ic_per = cfg[REG_IN_CH] / cfg[REG_GROUPS];
    oc_per = cfg[REG_OUT_CH] / cfg[REG_GROUPS];
    first = (oc / oc_per) * ic_per;
    for (int ch = first; ch < first + ic_per; ch++) begin
      for (int i = 0; i < cfg[REG_KERNEL]; i++) begin
        for (int j = 0; j < cfg[REG_KERNEL]; j++) begin
          if (!w_written[oc][ch][i][j]) send(CMD_LOAD_W, oc, ch, i, j, pick_value());
          ih = r * cfg[REG_STRIDE] + i - cfg[REG_PAD];
          iw = cl * cfg[REG_STRIDE] + j - cfg[REG_PAD];
          if (ih >= 0 && ih < cfg[REG_HEIGHT] && iw >= 0 && iw < cfg[REG_WIDTH] &&
              !x_written[ch][ih][iw])
            send(CMD_LOAD_X, 0, ch, ih, iw, pick_value());
        end
      end
    end
    send(CMD_COMPUTE, oc, $urandom_range(0, 15), r, cl, 16'($urandom()));
  endtask

  task automatic apb_write(input reg_e r, input int v);
    @(posedge clk_i);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Lets every outstanding result come back, then lets any last compute
  // finish, before the registers change.
  task automatic drain();
    cmd_bus.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input int ic, input int oc, input int g, input int k,
                            input int s, input int p, input int h, input int w);
    int vals[8];
    vals = '{ic, oc, g, k, s, p, h, w};
    drain();
    for (int i = 0; i < 8; i++) begin
      apb_write(reg_e'(i), vals[i]);
      cfg[i] = vals[i];
    end
  endtask

  // Random traffic under the present registers. With a sane setting most
  // computes land on legal positions with their data primed; otherwise only
  // raw field values are used.
  task automatic run_random(input int n, input bit sane);
    int p, ic, oc, rows, cols, r, c;
    rows = sane ? axis_len(cfg[REG_HEIGHT]) : 0;
    cols = sane ? axis_len(cfg[REG_WIDTH]) : 0;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      ic = $urandom_range(0, sane ? cfg[REG_IN_CH] - 1 : 15);
      oc = $urandom_range(0, sane ? cfg[REG_OUT_CH] - 1 : 15);
      if (p < 35 && sane) begin
        send(CMD_LOAD_X, $urandom_range(0, 15), ic, $urandom_range(0, cfg[REG_HEIGHT] - 1),
             $urandom_range(0, cfg[REG_WIDTH] - 1), pick_value());
      end else if (p < 55 && sane) begin
        send(CMD_LOAD_W, oc, ic, $urandom_range(0, cfg[REG_KERNEL] - 1),
             $urandom_range(0, cfg[REG_KERNEL] - 1), pick_value());
      end else if (p < 65) begin
        send($urandom_range(0, 1) ? CMD_LOAD_X : CMD_LOAD_W, $urandom_range(0, 15),
             $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 31),
             16'($urandom()));
      end else if (p < 69) begin
        send(CMD_NONE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 31),
             $urandom_range(0, 31), 16'($urandom()));
      end else if (sane && rows > 0 && cols > 0 && p < 92) begin
        send_compute(oc, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1));
      end else begin
        // Computes with raw fields; those outside the output map must flag,
        // and those that land inside it get their data primed first.
        oc = $urandom_range(0, 15);
        r = $urandom_range(0, 31);
        c = $urandom_range(0, 31);
        if (sane && oc < cfg[REG_OUT_CH] && r < rows && c < cols) begin
          send_compute(oc, r, c);
        end else begin
          send(CMD_COMPUTE, oc, $urandom_range(0, 15), r, c, 16'($urandom()));
        end
      end
    end
  endtask

  initial begin
    rst_ni = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    beats_sent = 0;
    cmd_bus.valid = 0;
    cmd_bus.command = CMD_NONE;
    cmd_bus.dst_ch = 0;
    cmd_bus.src_ch = 0;
    cmd_bus.row = 0;
    cmd_bus.col = 0;
    cmd_bus.value = 0;
    cfg = '{1, 1, 1, 3, 1, 0, 32, 32};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed beats under the reset settings: value extremes, a load past
    // the kernel edge that must be dropped, the unused command code, both
    // corners of the output map and positions just past it.
    send(CMD_LOAD_W, 0, 0, 0, 0, 16'sh7fff);
    send(CMD_LOAD_W, 0, 0, 0, 1, 16'sh8000);
    send(CMD_LOAD_X, 15, 0, 0, 0, 16'sh8000);
    send(CMD_LOAD_X, 0, 0, 0, 1, 16'sh8000);
    send(CMD_LOAD_W, 0, 0, 3, 0, 16'sh1234);
    send(CMD_LOAD_X, 0, 1, 0, 0, 16'sh4321);
    send(CMD_NONE, 15, 15, 31, 31, 16'shffff);
    send_compute(0, 0, 0);
    send_compute(0, 29, 29);
    send(CMD_COMPUTE, 0, 0, 30, 0, 0);
    send(CMD_COMPUTE, 0, 0, 0, 30, 0);
    send(CMD_COMPUTE, 1, 0, 0, 0, 0);
    send(CMD_COMPUTE, 15, 15, 31, 31, 0);

    // Register settings, from ordinary through the extremes to broken ones.
    set_config(4, 4, 2, 3, 1, 1, 6, 6);
    run_random(60, 1);
    set_config(16, 16, 16, 7, 4, 3, 8, 8);
    run_random(6, 1);
    set_config(6, 3, 3, 3, 2, 2, 9, 7);
    run_random(35, 1);
    set_config(2, 8, 1, 1, 1, 0, 1, 1);
    run_random(30, 1);
    set_config(16, 16, 1, 1, 3, 0, 10, 10);
    run_random(8, 1);
    set_config(1, 1, 1, 7, 1, 0, 3, 3);
    run_random(15, 1);
    set_config(4, 4, 3, 3, 1, 1, 8, 8);
    run_random(15, 0);
    set_config(31, 0, 0, 0, 0, 3, 63, 0);
    run_random(12, 0);
    set_config(20, 4, 1, 3, 7, 0, 40, 33);
    run_random(12, 0);
    set_config(8, 4, 4, 3, 2, 1, 8, 5);
    run_random(20, 1);
    set_config(3, 6, 3, 2, 1, 3, 4, 4);
    run_random(30, 1);

    drain();
    if (fail_count == 0) begin
      $display("** grouped_conv2d_engine: PASSED **");
    end else begin
      $display("** grouped_conv2d_engine: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/gc2d_pkg.sv
src/gc2d_if.sv
src/gc2d_ram.sv
src/gc2d_mac.sv
src/grouped_conv2d_engine.sv
sim/gc2d_checker.sv
sim/grouped_conv2d_engine_tb.sv
